// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on the rising clock edge and
// switched off while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AAMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define AAMS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/aams_pkg.sv =====
// ----------------------------------------------------------------------------
// aams_pkg
// Shared constants, register codes and types of the argmin/argmax block.
// ----------------------------------------------------------------------------
package aams_pkg;

	localparam int MAX_DIMS_DEF     = 4;
	localparam int VALUE_WIDTH_DEF  = 32;
	localparam int EXTENT_WIDTH_DEF = 16;

	localparam int VAL_W        = 32;
	localparam int POS_W        = 16;
	localparam int LIN_W        = 32;
	localparam int KEY_W        = 64;
	localparam int NUM_POS_OUT  = 4;
	localparam int NUM_EXT_REGS = 4;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [KEY_W-1:0] KEY_BIAS = {1'b1, {(KEY_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SELECT_MAX   = 3'd0,
		REG_COMPLEX_MODE = 3'd1,
		REG_EXTENT_0     = 3'd2,
		REG_EXTENT_1     = 3'd3,
		REG_EXTENT_2     = 3'd4,
		REG_EXTENT_3     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic s1_valid;
		logic s1_last;
		logic stall;
	} back_stat_t;

	// packed width of one queue entry: re, im, last, complex flag, subscripts, linear
	function automatic int entry_width(int vw, int md, int ew);
		return 2*vw + 2 + md*ew + LIN_W;
	endfunction

endpackage

// ===== sv/aams_elem_if.sv =====
// ----------------------------------------------------------------------------
// aams_elem_if
// Element input channel: one array element per item.
// ----------------------------------------------------------------------------
interface aams_elem_if;
	import aams_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value_re;
	logic signed [VAL_W-1:0] value_im;
	logic                    last_elem;

	modport source (output valid, output value_re, output value_im, output last_elem,
		input ready);
	modport sink (input valid, input value_re, input value_im, input last_elem,
		output ready);
endinterface

// ===== sv/aams_res_if.sv =====
// ----------------------------------------------------------------------------
// aams_res_if
// Result channel: winning value with its subscripts and linear position.
// ----------------------------------------------------------------------------
interface aams_res_if;
	import aams_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] best_re;
	logic signed [VAL_W-1:0] best_im;
	logic [POS_W-1:0]        pos_0;
	logic [POS_W-1:0]        pos_1;
	logic [POS_W-1:0]        pos_2;
	logic [POS_W-1:0]        pos_3;
	logic [LIN_W-1:0]        linear_pos;

	modport source (output valid, output best_re, output best_im, output pos_0,
		output pos_1, output pos_2, output pos_3, output linear_pos, input ready);
	modport sink (input valid, input best_re, input best_im, input pos_0,
		input pos_1, input pos_2, input pos_3, input linear_pos, output ready);
endinterface

// ===== sv/aams_cfg_if.sv =====
// ----------------------------------------------------------------------------
// aams_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface aams_cfg_if;
	import aams_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/aams_front.sv =====
// ----------------------------------------------------------------------------
// aams_front
// Takes element items, tags each with its subscripts and linear position
// from the wrapping position counters, and pushes it into the queue.
// ----------------------------------------------------------------------------
module aams_front #(
	parameter int MAX_DIMS     = aams_pkg::MAX_DIMS_DEF,
	parameter int VALUE_WIDTH  = aams_pkg::VALUE_WIDTH_DEF,
	parameter int EXTENT_WIDTH = aams_pkg::EXTENT_WIDTH_DEF,
	parameter int ENTRY_W      = aams_pkg::entry_width(aams_pkg::VALUE_WIDTH_DEF,
		aams_pkg::MAX_DIMS_DEF, aams_pkg::EXTENT_WIDTH_DEF)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	aams_elem_if.sink               elem,
	input  logic                    complex_mode,
	input  logic [EXTENT_WIDTH-1:0] extent [MAX_DIMS],
	output logic                    push_valid,
	input  logic                    push_ready,
	output logic [ENTRY_W-1:0]      push_data
);
	import aams_pkg::*;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0]          re;
		logic signed [VALUE_WIDTH-1:0]          im;
		logic                                   last;
		logic                                   cplx;
		logic [MAX_DIMS-1:0][EXTENT_WIDTH-1:0]  pos;
		logic [LIN_W-1:0]                       linear;
	} entry_t;

	logic [EXTENT_WIDTH-1:0] cur_pos_q [MAX_DIMS];
	logic [LIN_W-1:0]        cur_lin_q;
	logic [EXTENT_WIDTH-1:0] nxt       [MAX_DIMS];
	logic                    wrap      [MAX_DIMS];
	logic                    carry     [MAX_DIMS];
	logic                    accept;
	entry_t                  entry;

	assign elem.ready = push_ready;
	assign push_valid = elem.valid;
	assign accept     = elem.valid && push_ready;

	// an extent of zero wraps like one; a dimension steps only when all below wrap
	always_comb begin
		for (int d = 0; d < MAX_DIMS; d++) begin
			nxt[d]  = cur_pos_q[d] + EXTENT_WIDTH'(1);
			wrap[d] = (nxt[d] >= extent[d]) || (nxt[d] == '0);
		end
		carry[0] = 1'b1;
		for (int d = 1; d < MAX_DIMS; d++) begin
			carry[d] = carry[d-1] && wrap[d-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				cur_pos_q[d] <= '0;
			end
			cur_lin_q <= '0;
		end else if (accept) begin
			if (elem.last_elem) begin
				for (int d = 0; d < MAX_DIMS; d++) begin
					cur_pos_q[d] <= '0;
				end
				cur_lin_q <= '0;
			end else begin
				for (int d = 0; d < MAX_DIMS; d++) begin
					if (carry[d]) begin
						cur_pos_q[d] <= wrap[d] ? '0 : nxt[d];
					end
				end
				cur_lin_q <= cur_lin_q + LIN_W'(1);
			end
		end
	end

	always_comb begin
		entry.re     = elem.value_re[VALUE_WIDTH-1:0];
		entry.im     = complex_mode ? elem.value_im[VALUE_WIDTH-1:0] : '0;
		entry.last   = elem.last_elem;
		entry.cplx   = complex_mode;
		for (int d = 0; d < MAX_DIMS; d++) begin
			entry.pos[d] = cur_pos_q[d];
		end
		entry.linear = cur_lin_q;
	end

	assign push_data = entry;

endmodule

// ===== sv/aams_queue.sv =====
// ----------------------------------------------------------------------------
// aams_queue
// Small register FIFO decoupling the tagging front from the compare back.
// ----------------------------------------------------------------------------
module aams_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = aams_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import aams_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/aams_back.sv =====
// ----------------------------------------------------------------------------
// aams_back
// Squares the parts, forms the key, keeps the running winner and loads the
// result register on the item that closes a block.
// ----------------------------------------------------------------------------
module aams_back #(
	parameter int MAX_DIMS     = aams_pkg::MAX_DIMS_DEF,
	parameter int VALUE_WIDTH  = aams_pkg::VALUE_WIDTH_DEF,
	parameter int EXTENT_WIDTH = aams_pkg::EXTENT_WIDTH_DEF,
	parameter int ENTRY_W      = aams_pkg::entry_width(aams_pkg::VALUE_WIDTH_DEF,
		aams_pkg::MAX_DIMS_DEF, aams_pkg::EXTENT_WIDTH_DEF)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 select_max,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  logic [ENTRY_W-1:0]   pop_data,
	aams_res_if.source           res,
	output aams_pkg::back_stat_t stat
);
	import aams_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam int SQ_W = 2*VW;

	typedef struct packed {
		logic signed [VW-1:0]                   re;
		logic signed [VW-1:0]                   im;
		logic                                   last;
		logic                                   cplx;
		logic [MAX_DIMS-1:0][EXTENT_WIDTH-1:0]  pos;
		logic [LIN_W-1:0]                       linear;
	} entry_t;

	function automatic logic [VW-1:0] magnitude(logic [VW-1:0] x);
		return x[VW-1] ? (~x + VW'(1)) : x;
	endfunction

	entry_t             head;
	logic [VW-1:0]      mag_re;
	logic [VW-1:0]      mag_im;

	logic               valid_s1;
	entry_t             item_s1;
	logic [SQ_W-1:0]    sq_re_s1;
	logic [SQ_W-1:0]    sq_im_s1;

	logic [SQ_W:0]      mag_sum;
	logic [KEY_W-1:0]   key;
	logic               take;
	logic               s1_fire;
	logic               out_free;

	logic [KEY_W-1:0]                       best_key_q;
	logic signed [VW-1:0]                   best_re_q;
	logic signed [VW-1:0]                   best_im_q;
	logic [MAX_DIMS-1:0][EXTENT_WIDTH-1:0]  best_pos_q;
	logic [LIN_W-1:0]                       best_lin_q;
	logic                                   first_q;

	logic signed [VW-1:0]                   win_re;
	logic signed [VW-1:0]                   win_im;
	logic [MAX_DIMS-1:0][EXTENT_WIDTH-1:0]  win_pos;
	logic [LIN_W-1:0]                       win_lin;

	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_re_q;
	logic signed [VAL_W-1:0] out_im_q;
	logic [LIN_W-1:0]        out_lin_q;
	logic [POS_W-1:0]        out_pos [NUM_POS_OUT];

	assign head   = entry_t'(pop_data);
	assign mag_re = magnitude(head.re);
	assign mag_im = magnitude(head.im);

	// a closing item waits in s1 until the result register is free
	assign out_free  = !out_valid_q || res.ready;
	assign s1_fire   = valid_s1 && (!item_s1.last || out_free);
	assign pop_ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop_ready) begin
			valid_s1 <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			item_s1  <= head;
			sq_re_s1 <= SQ_W'(mag_re) * SQ_W'(mag_re);
			sq_im_s1 <= SQ_W'(mag_im) * SQ_W'(mag_im);
		end
	end

	// real keys are sign-biased so that both kinds compare as unsigned
	always_comb begin
		mag_sum = (SQ_W+1)'(sq_re_s1) + (SQ_W+1)'(sq_im_s1);
		key     = item_s1.cplx ? KEY_W'(mag_sum) : (KEY_W'(item_s1.re) ^ KEY_BIAS);
		take    = first_q || (select_max ? (key > best_key_q) : (key < best_key_q));
		win_re  = take ? item_s1.re     : best_re_q;
		win_im  = take ? item_s1.im     : best_im_q;
		win_pos = take ? item_s1.pos    : best_pos_q;
		win_lin = take ? item_s1.linear : best_lin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (s1_fire) begin
			first_q <= item_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && take) begin
			best_key_q <= key;
			best_re_q  <= item_s1.re;
			best_im_q  <= item_s1.im;
			best_pos_q <= item_s1.pos;
			best_lin_q <= item_s1.linear;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && item_s1.last) begin
			out_re_q  <= VAL_W'(win_re);
			out_im_q  <= VAL_W'(win_im);
			out_lin_q <= win_lin;
		end
	end

	for (genvar k = 0; k < NUM_POS_OUT; k++) begin : g_pos
		if (k < MAX_DIMS) begin : g_used
			logic [POS_W-1:0] pos_q;
			always_ff @(posedge clk) begin
				if (s1_fire && item_s1.last) begin
					pos_q <= POS_W'(win_pos[k]);
				end
			end
			assign out_pos[k] = pos_q;
		end else begin : g_unused
			assign out_pos[k] = '0;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.best_re    = out_re_q;
	assign res.best_im    = out_im_q;
	assign res.pos_0      = out_pos[0];
	assign res.pos_1      = out_pos[1];
	assign res.pos_2      = out_pos[2];
	assign res.pos_3      = out_pos[3];
	assign res.linear_pos = out_lin_q;

	assign stat.s1_valid = valid_s1;
	assign stat.s1_last  = item_s1.last;
	assign stat.stall    = valid_s1 && !s1_fire;

endmodule

// ===== sv/argmin_argmax_with_subscript.sv =====
// ----------------------------------------------------------------------------
// argmin_argmax_with_subscript
// Path to a result: queue, compare stage s1, result register. Throughput:
// one element per cycle while the queue has room, set by the key compare
// and winner update loop in the back end; results stall only on the result
// port. Reset: counters cleared, minimum search, real mode, all extents 1;
// no clearing pass, elements are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module argmin_argmax_with_subscript #(
	parameter int MAX_DIMS     = aams_pkg::MAX_DIMS_DEF,
	parameter int VALUE_WIDTH  = aams_pkg::VALUE_WIDTH_DEF,
	parameter int EXTENT_WIDTH = aams_pkg::EXTENT_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	aams_elem_if.sink elem,
	aams_res_if.source res,
	aams_cfg_if.sink  cfg
);
	import aams_pkg::*;

	localparam int ENTRY_W = entry_width(VALUE_WIDTH, MAX_DIMS, EXTENT_WIDTH);

	logic                    select_max_q;
	logic                    complex_mode_q;
	logic [EXTENT_WIDTH-1:0] extent_w [MAX_DIMS];
	logic                    cfg_fire;

	logic                    q_push_valid;
	logic                    q_push_ready;
	logic [ENTRY_W-1:0]      q_push_data;
	logic                    q_pop_valid;
	logic                    q_pop_ready;
	logic [ENTRY_W-1:0]      q_pop_data;
	back_stat_t              stat;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_max_q   <= 1'b0;
			complex_mode_q <= 1'b0;
		end else if (cfg_fire) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_SELECT_MAX:   select_max_q   <= cfg.data[0];
				REG_COMPLEX_MODE: complex_mode_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// dimensions without a register keep an extent of one
	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_ext
		if (d < NUM_EXT_REGS) begin : g_reg
			logic [EXTENT_WIDTH-1:0] ext_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ext_q <= EXTENT_WIDTH'(1);
				end else if (cfg_fire &&
						cfg.index == CFG_IDX_W'(int'(REG_EXTENT_0) + d)) begin
					ext_q <= cfg.data[EXTENT_WIDTH-1:0];
				end
			end
			assign extent_w[d] = ext_q;
		end else begin : g_fixed
			assign extent_w[d] = EXTENT_WIDTH'(1);
		end
	end

	aams_front #(
		.MAX_DIMS     (MAX_DIMS),
		.VALUE_WIDTH  (VALUE_WIDTH),
		.EXTENT_WIDTH (EXTENT_WIDTH),
		.ENTRY_W      (ENTRY_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.elem         (elem),
		.complex_mode (complex_mode_q),
		.extent       (extent_w),
		.push_valid   (q_push_valid),
		.push_ready   (q_push_ready),
		.push_data    (q_push_data)
	);

	aams_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	aams_back #(
		.MAX_DIMS     (MAX_DIMS),
		.VALUE_WIDTH  (VALUE_WIDTH),
		.EXTENT_WIDTH (EXTENT_WIDTH),
		.ENTRY_W      (ENTRY_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.select_max (select_max_q),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data),
		.res        (res),
		.stat       (stat)
	);

	// an item waiting at the queue head is not dropped
	`AAMS_ASSERT_NXT(a_queue_head_kept, clk, arst_n, q_pop_valid && !q_pop_ready, q_pop_valid, "queue head lost while back end stalled")
	// a stalled closing item stays in the compare stage
	`AAMS_ASSERT_NXT(a_close_held, clk, arst_n, stat.stall, stat.s1_valid && stat.s1_last, "stalled closing item left the compare stage")
	// a result only ever follows a closing item in the compare stage
	`AAMS_ASSERT_IMP(a_result_origin, clk, arst_n, $rose(res.valid), $past(stat.s1_valid && stat.s1_last), "result raised without a closing item")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming argmin/argmax block. Directed and
// random element streams under changing register settings are predicted by
// an in-bench model of the running winner, its subscripts and linear
// position; every result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import aams_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam int RANDOM_ITEMS  = 1450;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 150;
	localparam int IDLE_PCT      = 23;

	typedef struct packed {
		logic [VAL_W-1:0]                  re;
		logic [VAL_W-1:0]                  im;
		logic [NUM_POS_OUT-1:0][POS_W-1:0] pos;
		logic [LIN_W-1:0]                  lin;
	} winner_t;

	class winner_tracker;
		bit                                sel_max;
		bit                                cplx;
		bit                                fresh;
		logic [NUM_POS_OUT-1:0][POS_W-1:0] extent;
		logic [NUM_POS_OUT-1:0][POS_W-1:0] cur_pos;
		logic [LIN_W-1:0]                  cur_lin;
		logic [KEY_W-1:0]                  best_key;
		winner_t                           best;
		winner_t                           due[$];
		int                                errors;
		int                                checked;

		function new();
			sel_max = 1'b0;
			cplx = 1'b0;
			for (int d = 0; d < NUM_POS_OUT; d++)
				extent[d] = 16'd1;
			cur_pos = '0;
			cur_lin = '0;
			best_key = '0;
			best = '0;
			fresh = 1'b1;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SELECT_MAX:   sel_max = data[0];
				REG_COMPLEX_MODE: cplx = data[0];
				REG_EXTENT_0:     extent[0] = data;
				REG_EXTENT_1:     extent[1] = data;
				REG_EXTENT_2:     extent[2] = data;
				REG_EXTENT_3:     extent[3] = data;
				default: ;
			endcase
		endfunction

		function logic [KEY_W-1:0] mag_sq(logic signed [KEY_W-1:0] v);
			logic [KEY_W-1:0] m;
			m = v[KEY_W-1] ? -v : v;
			return m * m;
		endfunction

		// odometer step; a zero extent wraps like an extent of one
		function void advance();
			logic [POS_W-1:0] nxt;
			bit carry;
			cur_lin = cur_lin + 1'b1;
			carry = 1'b1;
			for (int d = 0; d < NUM_POS_OUT; d++) begin
				if (carry) begin
					nxt = cur_pos[d] + 1'b1;
					if (nxt >= extent[d] || nxt == '0) begin
						cur_pos[d] = '0;
					end else begin
						cur_pos[d] = nxt;
						carry = 1'b0;
					end
				end
			end
		endfunction

		function void note_element(logic signed [VAL_W-1:0] re, logic signed [VAL_W-1:0] im,
			logic last);
			logic signed [KEY_W-1:0] re_x;
			logic signed [KEY_W-1:0] im_x;
			logic [KEY_W-1:0] key;
			bit take;
			re_x = re;
			if (cplx)
				im_x = im;
			else
				im_x = '0;
			// real keys are sign-biased so that both modes compare unsigned
			if (cplx)
				key = mag_sq(re_x) + mag_sq(im_x);
			else
				key = re_x ^ KEY_BIAS;
			if (fresh)
				take = 1'b1;
			else if (sel_max)
				take = key > best_key;
			else
				take = key < best_key;
			if (take) begin
				best_key = key;
				best.re = re_x[VAL_W-1:0];
				best.im = im_x[VAL_W-1:0];
				best.pos = cur_pos;
				best.lin = cur_lin;
				fresh = 1'b0;
			end
			if (last) begin
				due.push_back(best);
				cur_pos = '0;
				cur_lin = '0;
				fresh = 1'b1;
			end else begin
				advance();
			end
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40)
				$display("[%0t] error: %s", $time, what);
		endtask

		task check_winner(winner_t got);
			winner_t want;
			if (due.size() == 0) begin
				report($sformatf("result with none expected: re %h lin %0d", got.re, got.lin));
				return;
			end
			want = due.pop_front();
			checked++;
			if (got.re !== want.re)
				report($sformatf("best_re got %h want %h", got.re, want.re));
			if (got.im !== want.im)
				report($sformatf("best_im got %h want %h", got.im, want.im));
			for (int d = 0; d < NUM_POS_OUT; d++)
				if (got.pos[d] !== want.pos[d])
					report($sformatf("pos_%0d got %0d want %0d", d, got.pos[d], want.pos[d]));
			if (got.lin !== want.lin)
				report($sformatf("linear_pos got %0d want %0d", got.lin, want.lin));
		endtask

		task wrap_up();
			while (due.size() != 0) begin
				report($sformatf("result never arrived: lin %0d", due[0].lin));
				void'(due.pop_front());
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	aams_elem_if elem_ch();
	aams_res_if  res_ch();
	aams_cfg_if  cfg_ch();

	winner_tracker tracker = new();
	int sent = 0;
	int reg_writes = 0;
	int phases = 0;
	int hold_left = 0;
	bit steady = 1'b0;

	argmin_argmax_with_subscript uut (
		.clk(clk),
		.arst_n(arst_n),
		.elem(elem_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", tracker.due.size());
		$display("argmin_argmax_with_subscript: mismatch");
		$finish;
	end

	// result side: random back-pressure, plus a long hold-off when asked
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin : result_mon
		winner_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.best_re, res_ch.best_im, res_ch.pos_3, res_ch.pos_2, res_ch.pos_1,
				res_ch.pos_0, res_ch.linear_pos};
			tracker.check_winner(got);
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_element(input logic [VAL_W-1:0] re, input logic [VAL_W-1:0] im,
		input logic last);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			elem_ch.valid <= 1'b0;
			@(negedge clk);
		end
		elem_ch.valid     <= 1'b1;
		elem_ch.value_re  <= re;
		elem_ch.value_im  <= im;
		elem_ch.last_elem <= last;
		do @(posedge clk); while (!elem_ch.ready);
		tracker.note_element(re, im, last);
		sent++;
		@(negedge clk);
	endtask

	// leaves valid high so back-to-back writes need no gap
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.set_reg(idx, data);
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic configure(input bit sel, input bit cplx,
		input logic [NUM_POS_OUT-1:0][POS_W-1:0] ext, input bit spare);
		write_reg(REG_SELECT_MAX, {15'($urandom), sel});
		write_reg(REG_COMPLEX_MODE, {15'($urandom), cplx});
		write_reg(REG_EXTENT_0, ext[0]);
		write_reg(REG_EXTENT_1, ext[1]);
		write_reg(REG_EXTENT_2, ext[2]);
		write_reg(REG_EXTENT_3, ext[3]);
		if (spare) begin
			write_reg(REG_SPARE_6, 16'($urandom));
			write_reg(REG_SPARE_7, 16'($urandom));
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// drain all results, then let the pipeline empty of result-less items
	task automatic settle();
		elem_ch.valid <= 1'b0;
		while (tracker.due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2, 3, 4: return $urandom_range(8) - 32'd4; // near zero, so keys tie often
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_extent();
		case ($urandom_range(11))
			0: return '0;
			1: return '1;
			2: return POS_W'($urandom);
			default: return POS_W'($urandom_range(4, 1));
		endcase
	endfunction

	task automatic random_phase(input int target);
		logic [NUM_POS_OUT-1:0][POS_W-1:0] ext;
		int blocks;
		int len;
		int span;
		for (int d = 0; d < NUM_POS_OUT; d++)
			ext[d] = pick_extent();
		configure($urandom_range(1), $urandom_range(1), ext, $urandom_range(3) == 0);
		blocks = $urandom_range(8, 2);
		for (int b = 0; b < blocks && sent < target; b++) begin
			span = 1;
			for (int d = 0; d < NUM_POS_OUT; d++)
				if (span <= 64)
					span = span * ((ext[d] == '0) ? 1 : int'(ext[d]));
			// mostly whole blocks; now and then a count that disagrees with the extents
			len = (span <= 24 && $urandom_range(7) != 0) ? span : $urandom_range(20, 1);
			for (int i = 1; i <= len; i++)
				send_element(pick_value(), pick_value(), i == len);
		end
		// sometimes leave the block open across the next register change
		if ($urandom_range(2) == 0)
			repeat ($urandom_range(4, 1)) send_element(pick_value(), pick_value(), 1'b0);
		settle();
	endtask

	initial begin : stimulus
		int opening;
		arst_n = 1'b0;
		elem_ch.valid = 1'b0;
		elem_ch.value_re = '0;
		elem_ch.value_im = '0;
		elem_ch.last_elem = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: minimum, real, unit extents; imaginary part ignored
		send_element(32'd5, '1, 1'b0);
		send_element(VAL_MIN, VAL_MAX, 1'b0);
		send_element(VAL_MAX, VAL_MIN, 1'b1);
		settle();

		// maximum, repeated peak, zero extent, one element past the block
		configure(1'b1, 1'b0, {16'd1, 16'd0, 16'd3, 16'd2}, 1'b1);
		send_element(32'd1, 32'd0, 1'b0);
		send_element(VAL_MAX, 32'd0, 1'b0);
		send_element('1, 32'd0, 1'b0);
		send_element(32'd0, '1, 1'b0);
		send_element(VAL_MAX, 32'd0, 1'b0);
		send_element(32'd7, 32'd0, 1'b0);
		send_element(VAL_MIN, 32'd0, 1'b1);
		settle();

		// complex minimum, widest extents, equal magnitudes after the winner
		configure(1'b0, 1'b1, {16'hFFFF, 16'd0, 16'd1, 16'hFFFF}, 1'b0);
		send_element(32'd3, 32'd4, 1'b0);
		send_element(VAL_MIN, VAL_MIN, 1'b0);
		send_element(32'hFFFF_FFFC, 32'd3, 1'b0);
		send_element(32'd5, 32'd0, 1'b1);
		settle();

		// complex maximum, tie on the largest single-part magnitude
		configure(1'b1, 1'b1, {4{16'd1}}, 1'b0);
		send_element(32'd0, VAL_MIN, 1'b0);
		send_element(VAL_MIN, 32'd0, 1'b1);
		settle();

		// mode switched with the block still open
		configure(1'b0, 1'b0, {16'd1, 16'd1, 16'd1, 16'd4}, 1'b0);
		send_element(32'hFFFF_FFF9, 32'd9, 1'b0);
		send_element(32'd100, 32'd0, 1'b0);
		settle();
		write_reg(REG_COMPLEX_MODE, 16'd1);
		cfg_ch.valid <= 1'b0;
		send_element(32'd1, 32'd1, 1'b1);
		settle();

		// fastest extent shortened below the current position mid-block
		configure(1'b0, 1'b0, {16'd1, 16'd1, 16'd3, 16'd5}, 1'b0);
		send_element(32'd10, 32'd0, 1'b0);
		send_element(32'd20, 32'd0, 1'b0);
		send_element(32'd30, 32'd0, 1'b0);
		settle();
		write_reg(REG_EXTENT_0, 16'd2);
		cfg_ch.valid <= 1'b0;
		send_element(32'd40, 32'd0, 1'b0);
		send_element(32'hFFFF_FFFD, 32'd0, 1'b1);
		settle();

		opening = sent;
		while (sent < opening + RANDOM_ITEMS) begin
			steady = (phases >= 10 && phases < 15);
			if (phases == 3) begin
				// result port held off while single-element blocks keep coming
				hold_left = HOLD_CYCLES;
				repeat (40) send_element(pick_value(), pick_value(), 1'b1);
				settle();
			end
			random_phase(opening + RANDOM_ITEMS);
			phases++;
		end
		steady = 1'b0;

		settle();
		tracker.wrap_up();
		$display("covered %0d elements: directed opening, then %0d random register settings",
			sent, phases);
		$display("%0d register writes, %0d results compared, %0d errors", reg_writes,
			tracker.checked, tracker.errors);
		if (tracker.errors == 0)
			$display("argmin_argmax_with_subscript: match");
		else
			$display("argmin_argmax_with_subscript: mismatch");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/aams_pkg.sv
sv/aams_elem_if.sv
sv/aams_res_if.sv
sv/aams_cfg_if.sv
sv/aams_front.sv
sv/aams_queue.sv
sv/aams_back.sv
sv/argmin_argmax_with_subscript.sv
tb/tb.sv
